// File: hdl/fq7_pkg.sv
`timescale 1ns / 1ps

package fq7_pkg;

	localparam int TAPS       = 32;
	localparam int NUM_BANKS  = 4;
	localparam int BANK_COEFS = 8;
	localparam int NUM_COEF   = NUM_BANKS * BANK_COEFS;
	localparam int SAMPLE_W   = 8;
	localparam int ACC_W      = 16;
	localparam int Q_SHIFT    = 7;
	localparam int TAP_CNT_W  = 6;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 6;
	localparam int REG_IDX_W  = 3;
	localparam int REG_LSB    = 3;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [ACC_W-1:0]    acc_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_TAP_COUNT    = 3'd0,
		REG_COEFF_BANK_0 = 3'd1,
		REG_COEFF_BANK_1 = 3'd2,
		REG_COEFF_BANK_2 = 3'd3,
		REG_COEFF_BANK_3 = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [TAP_CNT_W-1:0]                 tap_count;
		logic [NUM_COEF-1:0][SAMPLE_W-1:0]    coeff;
	} cfg_t;

endpackage

// File: hdl/fq7_tap_cell.sv
`timescale 1ns / 1ps

module fq7_tap_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  fq7_pkg::sample_t x_in,
	input  fq7_pkg::sample_t coef,
	output fq7_pkg::sample_t x_q,
	output fq7_pkg::acc_t    prod_s1
);
	import fq7_pkg::*;

	// delay element, cleared so that samples before the first read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
		end else if (load) begin
			x_q <= x_in;
		end
	end

	// 8x8 signed product always fits 16 bits
	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1 <= acc_t'(coef * x_in);
		end
	end

endmodule

// File: hdl/fq7_cfg_regs.sv
`timescale 1ns / 1ps

module fq7_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [fq7_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [fq7_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [fq7_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                               pready,
	output fq7_pkg::cfg_t                      cfg
);
	import fq7_pkg::*;

	localparam int BANK_W = BANK_COEFS * SAMPLE_W;

	logic [TAP_CNT_W-1:0]              tap_count_q;
	logic [NUM_BANKS-1:0][BANK_W-1:0]  bank_q;
	reg_idx_t                          idx;
	logic                              wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[REG_LSB +: REG_IDX_W]);
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAP_CNT_W'(1);
			bank_q      <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_TAP_COUNT:    tap_count_q <= pwdata[TAP_CNT_W-1:0];
				REG_COEFF_BANK_0: bank_q[0]   <= pwdata[BANK_W-1:0];
				REG_COEFF_BANK_1: bank_q[1]   <= pwdata[BANK_W-1:0];
				REG_COEFF_BANK_2: bank_q[2]   <= pwdata[BANK_W-1:0];
				REG_COEFF_BANK_3: bank_q[3]   <= pwdata[BANK_W-1:0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_TAP_COUNT:    prdata = CFG_DATA_W'(tap_count_q);
			REG_COEFF_BANK_0: prdata = CFG_DATA_W'(bank_q[0]);
			REG_COEFF_BANK_1: prdata = CFG_DATA_W'(bank_q[1]);
			REG_COEFF_BANK_2: prdata = CFG_DATA_W'(bank_q[2]);
			REG_COEFF_BANK_3: prdata = CFG_DATA_W'(bank_q[3]);
			default:          prdata = '0;
		endcase
	end

	assign cfg.tap_count = tap_count_q;
	assign cfg.coeff     = bank_q;

endmodule

// File: hdl/fq7_sum_pipe.sv
`timescale 1ns / 1ps

module fq7_sum_pipe (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  fq7_pkg::acc_t    prod_s1 [fq7_pkg::TAPS],
	output logic             out_valid,
	input  logic             out_stall,
	output fq7_pkg::sample_t filtered_sample,
	output logic             overflow
);
	import fq7_pkg::*;

	localparam int GRP  = 4;
	localparam int N_S2 = (TAPS + GRP - 1) / GRP;
	localparam int N_S3 = (N_S2 + GRP - 1) / GRP;

	logic  v1_q, v2_q, v3_q, vo_q;
	logic  rdy1, rdy2, rdy3, rdyo;
	acc_t  sum_s2 [N_S2];
	acc_t  sum_s3 [N_S3];
	acc_t  nxt_s2 [N_S2];
	acc_t  nxt_s3 [N_S3];
	acc_t  acc;
	sample_t res_q;
	logic  ovf_q;

	// each stage moves on when the next one is empty or moving
	assign rdyo     = !vo_q | !out_stall;
	assign rdy3     = !v3_q | rdyo;
	assign rdy2     = !v2_q | rdy3;
	assign rdy1     = !v1_q | rdy2;
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (rdy1) v1_q <= in_valid;
			if (rdy2) v2_q <= v1_q;
			if (rdy3) v3_q <= v2_q;
			if (rdyo) vo_q <= v3_q;
		end
	end

	// sums wrap modulo 2^16
	always_comb begin
		for (int g = 0; g < N_S2; g++) begin
			nxt_s2[g] = '0;
			for (int j = 0; j < GRP; j++) begin
				if (g * GRP + j < TAPS) begin
					nxt_s2[g] = nxt_s2[g] + prod_s1[g * GRP + j];
				end
			end
		end
		for (int g = 0; g < N_S3; g++) begin
			nxt_s3[g] = '0;
			for (int j = 0; j < GRP; j++) begin
				if (g * GRP + j < N_S2) begin
					nxt_s3[g] = nxt_s3[g] + sum_s2[g * GRP + j];
				end
			end
		end
		acc = '0;
		for (int g = 0; g < N_S3; g++) begin
			acc = acc + sum_s3[g];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v1_q) sum_s2 <= nxt_s2;
		if (rdy3 && v2_q) sum_s3 <= nxt_s3;
		if (rdyo && v3_q) begin
			res_q <= acc[Q_SHIFT +: SAMPLE_W];
			// 9-bit shifted value fits a byte only when its top two bits agree
			ovf_q <= acc[ACC_W-1] ^ acc[ACC_W-2];
		end
	end

	assign out_valid       = vo_q;
	assign filtered_sample = res_q;
	assign overflow        = ovf_q;

`ifndef SYNTHESIS
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v1_q && v2_q && v3_q && vo_q))
		else $error("input stalled with an empty pipeline stage");

	a_full_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(v1_q && v2_q && v3_q && vo_q && out_stall) |-> in_stall)
		else $error("request taken into a full, blocked pipeline");

	a_stage3_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(v3_q && !out_stall) |=> out_valid)
		else $error("final stage result lost");

	a_stage2_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(v2_q && !out_stall) |=> v3_q)
		else $error("second stage result lost");
`endif

endmodule

// File: hdl/fir_filter_q7_int8_unit.sv
`timescale 1ns / 1ps

// streaming fir filter, signed 8-bit samples, signed q7 coefficients
// input channel: sample with sample_valid / sample_stall; a request is taken
//   at a clock edge with sample_valid high and sample_stall low
// output channel: filtered_sample and overflow with result_valid / result_stall,
//   one result per input request, in order
// configuration: apb-style port, 64-bit data, register i at byte address 8*i
//   (tap_count, coeff_bank_0..3); write only while no request is in flight
// pipeline: products are registered at the accepting edge, then pass two
//   adder levels and the output register before result_valid rises
// throughput: one request per clock unless stalled, set by the tap chain, where
//   every cell forms its product in the same cycle, and the pipelined adder tree
// receiver stall: the result holds; the earlier stages keep filling until
//   all four hold a request, then sample_stall goes high
// reset: the delay line clears to zero, tap_count goes to 1 and all
//   coefficients to zero; no result is pending after reset

module fir_filter_q7_int8_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [fq7_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [fq7_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [fq7_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                               pready,
	input  logic                               sample_valid,
	output logic                               sample_stall,
	input  fq7_pkg::sample_t                   sample,
	output logic                               result_valid,
	input  logic                               result_stall,
	output fq7_pkg::sample_t                   filtered_sample,
	output logic                               overflow
);
	import fq7_pkg::*;

	cfg_t    cfg;
	logic    accept;
	// x_chain[k] is x[n-k] for the request at the input
	sample_t x_chain [TAPS+1];
	sample_t coef    [TAPS];
	acc_t    prod_s1 [TAPS];

	// register block
	fq7_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign accept     = sample_valid & !sample_stall;
	assign x_chain[0] = sample;

	// tap chain: each cell holds one delayed sample and hands it on per request
	for (genvar k = 0; k < TAPS; k++) begin : g_tap
		if (k < NUM_COEF) begin : g_coef
			// taps at or beyond tap_count weigh zero; counts above TAPS saturate
			assign coef[k] = ({1'b0, cfg.tap_count} > (TAP_CNT_W + 1)'(k)) ?
				sample_t'(cfg.coeff[k]) : '0;
		end else begin : g_nocoef
			assign coef[k] = '0;
		end

		fq7_tap_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.load    (accept),
			.x_in    (x_chain[k]),
			.coef    (coef[k]),
			.x_q     (x_chain[k+1]),
			.prod_s1 (prod_s1[k])
		);
	end

	// adder tree and output register with per-stage flow control
	fq7_sum_pipe u_sum (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (sample_valid),
		.in_stall        (sample_stall),
		.prod_s1         (prod_s1),
		.out_valid       (result_valid),
		.out_stall       (result_stall),
		.filtered_sample (filtered_sample),
		.overflow        (overflow)
	);

endmodule

// File: tb/sv/fir_q7_checker.sv
`timescale 1ns / 1ps

// watches the config port and both streams, keeps its own filter state
// and compares every accepted result with the oldest expected one
module fir_q7_checker
	import fq7_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic                  pready,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	input  logic                  sample_valid,
	input  logic                  sample_stall,
	input  sample_t               sample,
	input  logic                  result_valid,
	input  logic                  result_stall,
	input  sample_t               filtered_sample,
	input  logic                  overflow,
	output int                    errors,
	output int                    pending
);

	typedef struct packed {
		sample_t value;
		logic    ovf;
	} fir_out_t;

	logic [TAP_CNT_W-1:0] tap_cfg;
	sample_t              coef [NUM_COEF];
	sample_t              history [TAPS-1];
	fir_out_t             expected_out [$];

	// direct-form sum in a wrapping 16-bit accumulator, then >>> 7
	function automatic fir_out_t fir_response(sample_t x);
		int         n;
		int         prod;
		sample_t    xk;
		acc_t       acc;
		logic [8:0] scaled;
		fir_out_t   r;
		n = (int'(tap_cfg) > TAPS) ? TAPS : int'(tap_cfg);
		acc = '0;
		for (int k = 0; k < n; k++) begin
			xk = (k == 0) ? x : history[k-1];
			prod = (k < NUM_COEF) ? int'(coef[k]) * int'(xk) : 0;
			acc = acc + acc_t'(prod);
		end
		scaled = acc[ACC_W-1:Q_SHIFT];
		r.value = scaled[SAMPLE_W-1:0];
		// 9-bit value fits a signed byte only when its two top bits agree
		r.ovf = scaled[SAMPLE_W] ^ scaled[SAMPLE_W-1];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fir_out_t want;
		int       bank;
		if (!arst_n) begin
			tap_cfg = TAP_CNT_W'(1);
			foreach (coef[i]) coef[i] = '0;
			foreach (history[i]) history[i] = '0;
			expected_out.delete();
			errors = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				bank = int'(paddr[REG_LSB +: REG_IDX_W]) - 1;
				case (paddr[REG_LSB +: REG_IDX_W])
					REG_TAP_COUNT: tap_cfg = pwdata[TAP_CNT_W-1:0];
					REG_COEFF_BANK_0, REG_COEFF_BANK_1, REG_COEFF_BANK_2,
					REG_COEFF_BANK_3: begin
						for (int b = 0; b < BANK_COEFS; b++)
							coef[bank*BANK_COEFS + b] = pwdata[SAMPLE_W*b +: SAMPLE_W];
					end
					default: ;
				endcase
			end
			// results first, so a result never meets a request of its own edge
			if (result_valid && !result_stall) begin
				if (expected_out.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, got filtered_sample %0d overflow %0b",
						$time, filtered_sample, overflow);
				end else begin
					want = expected_out.pop_front();
					if (filtered_sample !== want.value) begin
						errors++;
						$display("%0t: filtered_sample expected %0d got %0d",
							$time, want.value, filtered_sample);
					end
					if (overflow !== want.ovf) begin
						errors++;
						$display("%0t: overflow expected %0b got %0b",
							$time, want.ovf, overflow);
					end
				end
			end
			if (sample_valid && !sample_stall) begin
				expected_out.push_back(fir_response(sample));
				for (int k = TAPS - 2; k > 0; k--) history[k] = history[k-1];
				history[0] = sample;
			end
		end
		pending = expected_out.size();
	end

endmodule

// File: tb/sv/tb_fir_filter_q7_int8_unit.sv
`timescale 1ns / 1ps

// stimulus and verdict for the q7 fir unit; the checker beside the block
// predicts and compares, this module only drives and decides
module tb_fir_filter_q7_int8_unit;
	import fq7_pkg::*;

	// how a random coefficient bank is filled
	typedef enum int {COEF_WIDE, COEF_SMALL, COEF_EXTREME} coef_style_t;

	// first index past the register map, writes there must be ignored
	localparam logic [REG_IDX_W-1:0] REG_PAST_END = REG_IDX_W'(NUM_BANKS + 1);
	localparam int HOLD_CYCLES  = 80;  // long receiver hold-off
	localparam int DRAIN_CYCLES = 8;   // idle clocks after the final settle
	localparam int PHASES       = 12;
	localparam int PHASE_ITEMS  = 100;

	logic                  clk;
	logic                  arst_n       = 1'b0;
	logic                  psel         = 1'b0;
	logic                  penable      = 1'b0;
	logic                  pwrite       = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr        = '0;
	logic [CFG_DATA_W-1:0] pwdata       = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  sample_valid = 1'b0;
	logic                  sample_stall;
	sample_t               sample       = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	sample_t               filtered_sample;
	logic                  overflow;

	int errors;
	int pending;

	// idling knobs for the sender and the receiver
	bit tx_quiet    = 1'b0;
	bit rx_quiet    = 1'b0;
	int holds_asked = 0;

	fir_filter_q7_int8_unit u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.sample_valid    (sample_valid),
		.sample_stall    (sample_stall),
		.sample          (sample),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.filtered_sample (filtered_sample),
		.overflow        (overflow)
	);

	fir_q7_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.sample_valid    (sample_valid),
		.sample_stall    (sample_stall),
		.sample          (sample),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.filtered_sample (filtered_sample),
		.overflow        (overflow),
		.errors          (errors),
		.pending         (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop, far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// setup phase, then access phase held until pready, then psel drops to idle
	task automatic reg_write(input logic [REG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_ADDR_W'(idx) << REG_LSB;
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_filter(input int taps, input logic [CFG_DATA_W-1:0] b0, b1, b2, b3);
		reg_write(REG_TAP_COUNT, CFG_DATA_W'(taps));
		reg_write(REG_COEFF_BANK_0, b0);
		reg_write(REG_COEFF_BANK_1, b1);
		reg_write(REG_COEFF_BANK_2, b2);
		reg_write(REG_COEFF_BANK_3, b3);
	endtask

	// offer one request, maybe after a short gap, and wait until it is taken;
	// valid stays high between back-to-back requests
	task automatic feed(input int value);
		if (!tx_quiet && $urandom_range(99) < 18) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= sample_t'(value);
		do @(posedge clk); while (sample_stall);
	endtask

	// stop sending and wait until every expected result has come back;
	// the first edge lets the checker log the last accepted request
	task automatic settle();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] rand_bank(coef_style_t style);
		logic [CFG_DATA_W-1:0] b;
		for (int i = 0; i < BANK_COEFS; i++) begin
			case (style)
				COEF_WIDE:  b[SAMPLE_W*i +: SAMPLE_W] = SAMPLE_W'($urandom);
				// small taps keep the sum mostly in range, so non-overflow
				// results show up too
				COEF_SMALL: b[SAMPLE_W*i +: SAMPLE_W] = SAMPLE_W'($urandom_range(16) - 8);
				default:    b[SAMPLE_W*i +: SAMPLE_W] = $urandom_range(1) ? 8'h7f : 8'h80;
			endcase
		end
		return b;
	endfunction

	function automatic int rand_sample();
		if ($urandom_range(9) == 0)
			return $urandom_range(1) ? 127 : -128;
		return int'(sample_t'($urandom));
	endfunction

	// receiver: random stall about one cycle in five, a quiet phase with
	// none, and one long hold-off counted here
	initial begin
		int hold_left;
		int holds_done;
		hold_left  = 0;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (holds_done != holds_asked) begin
				holds_done = holds_asked;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (rx_quiet) begin
				result_stall <= 1'b0;
			end else begin
				result_stall <= ($urandom_range(99) < 21);
			end
		end
	end

	initial begin
		int          taps;
		int          r;
		coef_style_t style;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset state: one zero tap, empty delay line, so every output is zero
		feed(127);
		feed(-128);
		feed(0);
		feed(1);

		// two taps of -128: -128 * -128 twice wraps the accumulator to -32768,
		// a single product of 16384 overflows the byte range
		settle();
		load_filter(2, 64'h8080, '0, '0, '0);
		feed(-128);
		feed(-128);
		feed(127);
		feed(127);
		feed(-1);
		feed(0);

		// zero taps: nothing summed
		settle();
		reg_write(REG_TAP_COUNT, CFG_DATA_W'(0));
		feed(127);
		feed(-128);

		// tap count above the line length saturates to all 32 taps,
		// largest positive coefficients, heavy wrap of the sum;
		// a write past the register map must change nothing
		settle();
		load_filter(63, {8{8'h7f}}, {8{8'h7f}}, {8{8'h7f}}, {8{8'h7f}});
		reg_write(REG_PAST_END, '1);
		repeat (4) feed(127);
		repeat (4) feed(-128);

		// random phases, each with its own filter setting
		for (int p = 0; p < PHASES; p++) begin
			settle();
			if (p == 0) begin
				style = COEF_EXTREME;
				taps  = TAPS;
			end else begin
				style = coef_style_t'($urandom_range(2));
				r     = $urandom_range(99);
				if (r < 6)       taps = 0;
				else if (r < 14) taps = TAPS;
				else if (r < 20) taps = $urandom_range(63, TAPS + 1);
				else if (r < 28) taps = 1;
				else             taps = $urandom_range(TAPS - 1, 2);
			end
			load_filter(taps, rand_bank(style), rand_bank(style), rand_bank(style),
				rand_bank(style));
			if ($urandom_range(3) == 0)
				reg_write(REG_PAST_END, {$urandom, $urandom});

			// one phase runs with no idling on either side
			tx_quiet = (p == 6);
			rx_quiet = (p == 6);

			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// receiver holds off while the sender keeps pushing, so the
				// pipe fills and sample_stall rises
				if (p == 2 && i == 10)
					holds_asked++;
				// sender pauses until the pipe is empty
				if (p == 4 && i == 50)
					settle();
				feed(rand_sample());
			end
		end

		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: files.f
hdl/fq7_pkg.sv
hdl/fq7_tap_cell.sv
hdl/fq7_cfg_regs.sv
hdl/fq7_sum_pipe.sv
hdl/fir_filter_q7_int8_unit.sv
tb/sv/fir_q7_checker.sv
tb/sv/tb_fir_filter_q7_int8_unit.sv
